>>> rtl/core/zone_bitmap_allocator_core_assert.svh
// Assertion macros shared by the zone bitmap allocator RTL.
`ifndef ZONE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define ZONE_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ZBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ZBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/zba_pkg.sv
// Package: types, codes and constants of the zone bitmap allocator.
`timescale 1ns / 1ps

package zba_pkg;

  localparam int BITS_PER_MAP_BLOCK_DEF = 8192;
  localparam int MAP_BLOCKS_DEF         = 8;
  localparam int WORD_BITS              = 64;
  localparam int WORD_SH                = 6;
  localparam int ZONE_W                 = 17;
  localparam int FDZ_W                  = 16;
  localparam int CFG_IDX_W              = 8;
  localparam int CFG_DATA_W             = 17;

  localparam logic             CMD_ALLOC = 1'b0;
  localparam logic             CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_ZONE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ZONES     = 8'd1;

  localparam logic [FDZ_W-1:0]  FDZ_RESET = 16'd1;
  localparam logic [ZONE_W-1:0] TZ_RESET  = 17'd65536;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

  typedef struct packed {
    logic              cmd;
    logic [ZONE_W-1:0] zone_index;
  } req_beat_t;

  typedef struct packed {
    logic [ZONE_W-1:0] result_zone;
    status_t           status;
  } rsp_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_beat_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic scan_step;
    logic alloc_commit;
    logic free_read;
    logic range_fail;
    logic free_commit;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic range_bad;
    logic scan_stop;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/zba_stream_if.sv
// Valid/ready channel carrying one beat of a given payload type.
`timescale 1ns / 1ps

interface zba_stream_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

>>> rtl/core/zba_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module zba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/zba_ctrl.sv
// Controller state machine of the zone bitmap allocator.
`timescale 1ns / 1ps
`include "zone_bitmap_allocator_core_assert.svh"

module zba_ctrl
  import zba_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_free,
  output logic     req_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_CHK,
    S_FREE_UPD,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = req_free ? S_FREE_CHK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_stop) begin
          cmd.alloc_commit = 1'b1;
          state_next       = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FREE_CHK: begin
        if (sts.range_bad) begin
          cmd.range_fail = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.free_read = 1'b1;
          state_next    = S_FREE_UPD;
        end
      end
      S_FREE_UPD: begin
        cmd.free_commit = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  `ZBA_ASSERT_NEXT(a_accept_leaves_idle, state == S_IDLE && req_valid, state != S_IDLE, "accepted beat left controller idle")
  `ZBA_ASSERT_NEXT(a_clear_ends_idle, state == S_CLEAR && sts.clr_done, state == S_IDLE, "clear pass did not end in idle")
  `ZBA_ASSERT_SAME(a_load_needs_room, cmd.load_out, sts.out_free, "result loaded into a full output register")

endmodule

>>> rtl/core/zba_dp.sv
// Datapath: bitmap RAM, scan pointer, range checks and result registers.
`timescale 1ns / 1ps
`include "zone_bitmap_allocator_core_assert.svh"

module zba_dp
  import zba_pkg::*;
#(
  parameter int BITS_PER_MAP_BLOCK = BITS_PER_MAP_BLOCK_DEF,
  parameter int MAP_BLOCKS         = MAP_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  ctl_cmd_t  cmd,
  output dp_sts_t   sts,
  input  req_beat_t req_beat,
  zba_stream_if.sink   cfg,
  zba_stream_if.source rsp
);

  localparam int TOTAL_BITS = MAP_BLOCKS * BITS_PER_MAP_BLOCK;
  localparam int WORD_COUNT = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int B_W        = WIDX_W + WORD_SH;
  localparam int SUM_W      = ((B_W > ZONE_W) ? B_W : ZONE_W) + 1;
  localparam logic [WIDX_W-1:0] LAST = WIDX_W'(WORD_COUNT - 1);

  logic [FDZ_W-1:0]   first_data_zone;
  logic [ZONE_W-1:0]  total_zones;
  logic [FDZ_W-1:0]   base;

  logic [ZONE_W-1:0]  zone_q;
  logic [WIDX_W-1:0]  addr_q;
  logic [WIDX_W-1:0]  rd_addr_q;
  logic               rd_pend_q;
  logic [WIDX_W-1:0]  fword_q;
  logic [WORD_SH-1:0] fbit_q;

  logic [ZONE_W-1:0]  pend_zone;
  status_t            pend_st;
  logic               out_valid_q;
  logic [ZONE_W-1:0]  out_zone;
  status_t            out_st;

  logic                 ram_we;
  logic [WIDX_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WIDX_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] rdata;

  logic [WORD_BITS-1:0] holes;
  logic [WORD_BITS-1:0] low;
  logic [WORD_SH-1:0]   idx;
  logic [B_W-1:0]       bnum;
  logic [SUM_W-1:0]     bsum;
  logic                 alloc_full;
  logic [SUM_W-1:0]     off;
  logic                 fbit_set;
  logic                 clr_we;
  logic                 alloc_we;
  logic                 free_we;

  assign base = (first_data_zone == '0) ? '0 : first_data_zone - FDZ_W'(1);

  // lowest clear bit of the word just read
  assign holes = ~rdata;
  assign low   = holes & (~holes + WORD_BITS'(1));
  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low[i]) begin
        idx = idx | WORD_SH'(i);
      end
    end
  end
  assign bnum       = {rd_addr_q, idx};
  assign bsum       = SUM_W'(bnum) + SUM_W'(base);
  assign alloc_full = (holes == '0) || (SUM_W'(bnum) >= SUM_W'(TOTAL_BITS))
                      || (bsum >= SUM_W'(total_zones));

  assign off = SUM_W'(zone_q) - SUM_W'(base);
  assign sts.range_bad = (zone_q < ZONE_W'(base)) || (zone_q >= total_zones)
                         || (off >= SUM_W'(TOTAL_BITS));
  assign sts.clr_done  = (addr_q == LAST);
  assign sts.scan_stop = rd_pend_q && ((holes != '0) || (rd_addr_q == LAST));
  assign sts.out_free  = !out_valid_q || rsp.ready;

  assign fbit_set = rdata[fbit_q];
  assign clr_we   = cmd.clr_step;
  assign alloc_we = cmd.alloc_commit && !alloc_full;
  assign free_we  = cmd.free_commit && fbit_set;

  always_comb begin
    ram_we    = clr_we || alloc_we || free_we;
    ram_waddr = addr_q;
    ram_wdata = (addr_q == '0) ? WORD_BITS'(1) : '0;
    if (alloc_we) begin
      ram_waddr = rd_addr_q;
      ram_wdata = rdata | low;
    end else if (free_we) begin
      ram_waddr = fword_q;
      ram_wdata = rdata & ~(WORD_BITS'(1) << fbit_q);
    end
  end

  assign ram_re    = cmd.scan_step || cmd.free_read;
  assign ram_raddr = cmd.free_read ? off[B_W-1:WORD_SH] : addr_q;

  zba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_data_zone <= FDZ_RESET;
      total_zones     <= TZ_RESET;
      addr_q          <= '0;
      rd_pend_q       <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.beat.index)
          REG_FIRST_DATA_ZONE: first_data_zone <= cfg.beat.data[FDZ_W-1:0];
          REG_TOTAL_ZONES:     total_zones     <= cfg.beat.data[ZONE_W-1:0];
          default: ;
        endcase
      end
      rd_pend_q <= cmd.scan_step;
      if (cmd.capture) begin
        addr_q <= '0;
      end else if ((cmd.clr_step || cmd.scan_step) && addr_q != LAST) begin
        addr_q <= addr_q + WIDX_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      zone_q <= req_beat.zone_index;
    end
    if (cmd.scan_step) begin
      rd_addr_q <= addr_q;
    end
    if (cmd.free_read) begin
      fword_q <= off[B_W-1:WORD_SH];
      fbit_q  <= off[WORD_SH-1:0];
    end
    if (cmd.alloc_commit) begin
      pend_zone <= alloc_full ? '0 : bsum[ZONE_W-1:0];
      pend_st   <= alloc_full ? ST_FULL : ST_OK;
    end
    if (cmd.range_fail) begin
      pend_zone <= '0;
      pend_st   <= ST_RANGE;
    end
    if (cmd.free_commit) begin
      pend_zone <= fbit_set ? zone_q : '0;
      pend_st   <= fbit_set ? ST_OK : ST_DOUBLE;
    end
    if (cmd.load_out) begin
      out_zone <= pend_zone;
      out_st   <= pend_st;
    end
  end

  assign rsp.valid = out_valid_q;
  assign rsp.beat  = '{result_zone: out_zone, status: out_st};

  `ZBA_ASSERT_SAME(a_one_writer, 1'b1, $onehot0({clr_we, alloc_we, free_we}), "two map writes in one cycle")
  `ZBA_ASSERT_SAME(a_fail_zone_zero, out_valid_q && out_st != ST_OK, out_zone == '0, "failed beat carries a zone")
  `ZBA_ASSERT_NEXT(a_alloc_above_base, cmd.alloc_commit && !alloc_full, pend_zone >= ZONE_W'(base), "allocated zone below first data zone")

endmodule

>>> rtl/core/zone_bitmap_allocator_core.sv
// Top level of the zone bitmap allocator: controller, datapath and bitmap RAM.
//
// Channels: req carries a command (allocate or free) and a zone number; rsp
// returns one beat per request with the zone and a status (ok, full, out of
// range, double free); cfg writes first_data_zone (index 0) or total_zones
// (index 1) and is always ready. Write cfg only while the block is idle.
// Reset: a clearing pass writes every bitmap word (WORD_COUNT, 1024 by
// default), word 0 holding the reserved bit, one word a cycle; req stays
// not ready until it ends.
// A free goes through a range check, a map read and a map update before its
// result is loaded; a zone out of range skips the read and the update.
// An allocate scans the map one word a cycle through the RAM read port,
// stopping at the first word with a clear bit, or at the last word when the
// map is full.
// Throughput: one request at a time; the next req beat is taken the cycle
// after the result moves to the output register.
// Stall: the result waits in the output register while rsp is not ready; a
// further result holds in the datapath until that register is free.
`timescale 1ns / 1ps

module zone_bitmap_allocator_core
  import zba_pkg::*;
#(
  parameter int BITS_PER_MAP_BLOCK = BITS_PER_MAP_BLOCK_DEF,
  parameter int MAP_BLOCKS         = MAP_BLOCKS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  zba_stream_if.sink   req,
  zba_stream_if.source rsp,
  zba_stream_if.sink   cfg
);

  ctl_cmd_t  cmd;
  dp_sts_t   sts;
  req_beat_t req_beat;
  logic      req_ready;

  assign req_beat  = req.beat;
  assign req.ready = req_ready;

  zba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_free  (req_beat.cmd == CMD_FREE),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  zba_dp #(
    .BITS_PER_MAP_BLOCK (BITS_PER_MAP_BLOCK),
    .MAP_BLOCKS         (MAP_BLOCKS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_beat (req_beat),
    .cfg      (cfg),
    .rsp      (rsp)
  );

endmodule
